// File: rtl/qbd_pkg.sv
// qbd_pkg: shared types and constants of the quantized block dequantizer
// used by qbd_ctrl, qbd_fmul and quantized_block_dequantizer_unit
package qbd_pkg;

  localparam int MaxRowBlocks = 256;
  localparam int BlkW         = $clog2(MaxRowBlocks);
  localparam int BprW         = 9;
  localparam int IdxW         = 13;
  localparam int PosW         = 6;
  localparam int ProdW        = 18;

  localparam logic [1:0] CfgQuantFormat = 2'd0;
  localparam logic [1:0] CfgBlocksPerRow = 2'd1;

  localparam logic FmtQ4 = 1'b0;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;

  // one element waiting for the multiplier
  typedef struct packed {
    logic signed [7:0] q;
    logic [15:0]       scale;
    logic [IdxW-1:0]   idx;
    logic              last_blk;
    logic              last_row;
  } req_t;

  // product before normalization
  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic [7:0]       exp_base;
    logic             sign;
    logic             is_nan;
    logic             is_inf;
    logic [IdxW-1:0]  idx;
    logic             last_blk;
    logic             last_row;
  } prod_t;

endpackage

// File: rtl/qbd_ctrl.sv
// qbd_ctrl: byte sequencer, scale capture and held high nibbles
// depends on qbd_pkg
module qbd_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [8:0]            cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  output logic                  req_valid,
  output qbd_pkg::req_t         req,
  input  logic                  req_ready
);

  logic                          fmt_r;
  logic [qbd_pkg::BprW-1:0]      bpr_r;
  logic [qbd_pkg::PosW-1:0]      pos_r;
  logic [15:0]                   scale_r;
  logic [3:0]                    held_r [16];
  logic [qbd_pkg::BlkW-1:0]      blk_r;
  logic                          drain_r;
  logic [3:0]                    cnt_r;
  logic                          req_valid_r;
  qbd_pkg::req_t                 req_r;

  logic                          slot_free;
  logic                          acc;
  logic                          issue_drain;
  logic [qbd_pkg::BprW-1:0]      eff_blocks;
  logic                          row_end;
  logic [qbd_pkg::PosW-1:0]      j;
  logic                          data_byte;
  logic                          q4_last;
  logic                          q8_last;
  logic [qbd_pkg::IdxW-1:0]      blk_base;

  assign slot_free   = !req_valid_r || req_ready;
  assign in_tready   = !drain_r && slot_free;
  assign acc         = in_tvalid && in_tready;
  assign issue_drain = drain_r && slot_free;

  always_comb begin
    if (bpr_r == '0) begin
      eff_blocks = qbd_pkg::BprW'(1);
    end else if (bpr_r > qbd_pkg::BprW'(qbd_pkg::MaxRowBlocks)) begin
      eff_blocks = qbd_pkg::BprW'(qbd_pkg::MaxRowBlocks);
    end else begin
      eff_blocks = bpr_r;
    end
  end

  assign row_end   = (qbd_pkg::BprW'(blk_r) + qbd_pkg::BprW'(1)) >= eff_blocks;
  assign j         = pos_r - qbd_pkg::PosW'(2);
  assign data_byte = pos_r >= qbd_pkg::PosW'(2);
  assign q4_last   = (fmt_r == qbd_pkg::FmtQ4) && (j == qbd_pkg::PosW'(15));
  assign q8_last   = (fmt_r != qbd_pkg::FmtQ4) && (j == qbd_pkg::PosW'(31));
  assign blk_base  = {blk_r, 5'd0};

  // end of block bookkeeping shared by both formats
  logic end_blk;
  assign end_blk = (issue_drain && cnt_r == 4'd15) || (acc && data_byte && q8_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r   <= 1'b0;
      bpr_r   <= qbd_pkg::BprW'(1);
      pos_r   <= '0;
      scale_r <= '0;
      blk_r   <= '0;
      drain_r <= 1'b0;
      cnt_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == qbd_pkg::CfgQuantFormat) begin
        fmt_r <= cfg_wdata[0];
        pos_r <= '0;
        blk_r <= '0;
        drain_r <= 1'b0;
      end else if (cfg_index == qbd_pkg::CfgBlocksPerRow) begin
        bpr_r <= cfg_wdata;
        pos_r <= '0;
        blk_r <= '0;
        drain_r <= 1'b0;
      end
    end else begin
      if (acc) begin
        if (pos_r == '0) begin
          scale_r[7:0] <= in_tdata;
          pos_r <= qbd_pkg::PosW'(1);
        end else if (pos_r == qbd_pkg::PosW'(1)) begin
          scale_r[15:8] <= in_tdata;
          pos_r <= qbd_pkg::PosW'(2);
        end else if (q4_last) begin
          drain_r <= 1'b1;
          cnt_r   <= '0;
        end else if (!q8_last) begin
          pos_r <= pos_r + qbd_pkg::PosW'(1);
        end
      end
      if (issue_drain) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          drain_r <= 1'b0;
        end
      end
      if (end_blk) begin
        pos_r <= '0;
        blk_r <= row_end ? '0 : blk_r + qbd_pkg::BlkW'(1);
      end
    end
  end

  // high nibble store, only read after all entries of the block are written
  always_ff @(posedge clk) begin
    if (acc && data_byte && fmt_r == qbd_pkg::FmtQ4) begin
      held_r[j[3:0]] <= in_tdata[7:4];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (issue_drain) begin
      req_valid_r <= 1'b1;
    end else if (acc && data_byte) begin
      req_valid_r <= 1'b1;
    end else if (req_ready) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue_drain) begin
      req_r.q        <= $signed({4'd0, held_r[cnt_r]}) - 8'sd8;
      req_r.scale    <= scale_r;
      req_r.idx      <= blk_base + qbd_pkg::IdxW'({1'b1, cnt_r});
      req_r.last_blk <= cnt_r == 4'd15;
      req_r.last_row <= (cnt_r == 4'd15) && row_end;
    end else if (acc && data_byte) begin
      if (fmt_r == qbd_pkg::FmtQ4) begin
        req_r.q <= $signed({4'd0, in_tdata[3:0]}) - 8'sd8;
      end else begin
        req_r.q <= $signed(in_tdata);
      end
      req_r.scale    <= scale_r;
      req_r.idx      <= blk_base + qbd_pkg::IdxW'(j[4:0]);
      req_r.last_blk <= q8_last;
      req_r.last_row <= q8_last && row_end;
    end
  end

  assign req_valid = req_valid_r;
  assign req       = req_r;

endmodule

// File: rtl/qbd_fmul.sv
// qbd_fmul: exact quantized value times fp16 scale into fp32, two stages
// depends on qbd_pkg
module qbd_fmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       req_valid,
  input  qbd_pkg::req_t              req,
  output logic                       req_ready,
  output logic                       out_valid,
  output logic [31:0]                out_value,
  output logic [qbd_pkg::IdxW-1:0]   out_idx,
  output logic                       out_last_blk,
  output logic                       out_last_row,
  input  logic                       out_ready
);

  logic           s1_valid_r;
  qbd_pkg::prod_t s1_r;
  qbd_pkg::prod_t s1_nxt;
  logic           o_valid_r;
  logic [31:0]    o_value_r;
  logic [qbd_pkg::IdxW-1:0] o_idx_r;
  logic           o_lb_r;
  logic           o_lr_r;

  logic           o_free;
  logic           s1_free;

  assign o_free    = !o_valid_r || out_ready;
  assign s1_free   = !s1_valid_r || o_free;
  assign req_ready = s1_free;

  // stage one: integer product of magnitudes
  logic [4:0]  h_ex;
  logic [9:0]  h_man;
  logic [10:0] m;
  logic [7:0]  qmag;
  always_comb begin
    h_ex  = req.scale[14:10];
    h_man = req.scale[9:0];
    m     = (h_ex == 5'd0) ? {1'b0, h_man} : {1'b1, h_man};
    qmag  = req.q[7] ? 8'(-req.q) : 8'(req.q);
    s1_nxt.prod     = qbd_pkg::ProdW'(qmag) * qbd_pkg::ProdW'(m);
    s1_nxt.exp_base = (h_ex == 5'd0) ? 8'd103 : 8'(h_ex) + 8'd102;
    s1_nxt.sign     = req.q[7] ^ req.scale[15];
    s1_nxt.is_nan   = (h_ex == 5'd31) && ((h_man != '0) || (req.q == '0));
    s1_nxt.is_inf   = (h_ex == 5'd31) && (h_man == '0) && (req.q != '0);
    s1_nxt.idx      = req.idx;
    s1_nxt.last_blk = req.last_blk;
    s1_nxt.last_row = req.last_row;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && req_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // stage two: leading one search and packing
  logic [4:0]  msb;
  logic [40:0] shifted;
  logic [31:0] value_nxt;
  always_comb begin
    msb = '0;
    for (int i = 0; i < qbd_pkg::ProdW; i++) begin
      if (s1_r.prod[i]) begin
        msb = 5'(i);
      end
    end
    shifted = 41'(s1_r.prod) << (5'd23 - msb);
    if (s1_r.is_nan) begin
      value_nxt = qbd_pkg::CanonNan;
    end else if (s1_r.is_inf) begin
      value_nxt = {s1_r.sign, 8'hFF, 23'd0};
    end else if (s1_r.prod == '0) begin
      value_nxt = {s1_r.sign, 31'd0};
    end else begin
      value_nxt = {s1_r.sign, s1_r.exp_base + 8'(msb), shifted[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (o_free) begin
      o_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && s1_valid_r) begin
      o_value_r <= value_nxt;
      o_idx_r   <= s1_r.idx;
      o_lb_r    <= s1_r.last_blk;
      o_lr_r    <= s1_r.last_row;
    end
  end

  assign out_valid    = o_valid_r;
  assign out_value    = o_value_r;
  assign out_idx      = o_idx_r;
  assign out_last_blk = o_lb_r;
  assign out_last_row = o_lr_r;

endmodule

// File: rtl/quantized_block_dequantizer_unit.sv
// quantized_block_dequantizer_unit: top level of the row dequantizer
// depends on qbd_pkg, qbd_ctrl and qbd_fmul
//
// usage:
//   the in_ stream carries one byte of a compressed row per beat, in stored
//   order; each block opens with a little-endian fp16 scale, then 16 packed
//   nibble bytes (four-bit format) or 32 signed bytes (eight-bit format)
//   the out_ stream gives one fp32 element per beat with its index in the row;
//   tuser marks the last element of a block, tlast the last one of the row
//   the cfg_ port writes quant_format (index 0) and blocks_per_row (index 1); a write
//   to either restarts the row; user writes only while the block is idle, unenforced
// path: a data byte passes the request, stage one and output registers to out_
// throughput: one beat per cycle on each side while out_tready stays high and no
//   drain is running; the last nibble byte of a block also releases the 16 held
//   high elements, one per cycle from the element request register, and
//   in_tready stays low until all of them are issued
// reset: rst_n clears the sequencer to the start of a row, format four-bit,
//   one block per row; the held nibbles need no reset
// stall: a low out_tready holds the output register; the multiplier stages
//   and the request register keep filling until full, then in_tready drops
module quantized_block_dequantizer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // row_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // value_bits[31:0], element_index[44:32], zero fill
  output logic        out_tuser,  // last_in_block
  output logic        out_tlast   // last_in_row
);

  logic                      req_valid;
  qbd_pkg::req_t             req;
  logic                      req_ready;
  logic [31:0]               value;
  logic [qbd_pkg::IdxW-1:0]  idx;

  qbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .req_valid (req_valid),
    .req       (req),
    .req_ready (req_ready)
  );

  qbd_fmul u_fmul (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req          (req),
    .req_ready    (req_ready),
    .out_valid    (out_tvalid),
    .out_value    (value),
    .out_idx      (idx),
    .out_last_blk (out_tuser),
    .out_last_row (out_tlast),
    .out_ready    (out_tready)
  );

  assign out_tdata = {3'd0, idx, value};

endmodule

// File: sim/tb.sv
// tb: self-checking bench for quantized_block_dequantizer_unit
// depends on qbd_pkg and the dut rtl; predicts every element from the row bytes
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [31:0]              bits;
    logic [qbd_pkg::IdxW-1:0] idx;
    logic                     last_blk;
    logic                     last_row;
  } elem_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [8:0]  cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  quantized_block_dequantizer_unit u_dut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic        fmt_q8;
  logic [8:0]  row_blocks;
  int          byte_pos;
  logic [15:0] scale;
  logic [3:0]  high_nib [16];
  int          blk_num;

  logic [7:0] byte_q [$];
  elem_t      elem_q [$];
  int         errors = 0;
  int         send_idle = 0;
  int         recv_idle = 0;
  logic       in_fire = 1'b0;
  int         quiet_cycles = 0;

  function automatic int eff_blocks();
    if (row_blocks == 0) return 1;
    if (row_blocks > qbd_pkg::MaxRowBlocks) return qbd_pkg::MaxRowBlocks;
    return int'(row_blocks);
  endfunction

  // exact fp32 product of a small integer and an fp16 scale
  function automatic logic [31:0] scaled_bits(int q, logic [15:0] h);
    logic        s;
    int          mant, e2, mag, p;
    logic [31:0] frac;
    s = h[15] ^ (q < 0);
    if (h[14:10] == 5'h1F) begin
      if (h[9:0] != 0 || q == 0) return qbd_pkg::CanonNan;
      return {s, 8'hFF, 23'd0};
    end
    if (h[14:10] == 0) begin
      mant = h[9:0];
      e2 = -24;
    end else begin
      mant = {1'b1, h[9:0]};
      e2 = int'(h[14:10]) - 25;
    end
    mag = (q < 0 ? -q : q) * mant;
    if (mag == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 31; i++) if (mag >> i != 0) p = i;
    frac = (32'(mag) << (23 - p)) & 32'h7F_FFFF;
    return {s, 8'(p + e2 + 127), frac[22:0]};
  endfunction

  task automatic push_elem(int q, int e);
    elem_t x;
    x.bits = scaled_bits(q, scale);
    x.idx = qbd_pkg::IdxW'(blk_num * 32 + e);
    x.last_blk = (e == 31);
    x.last_row = (e == 31) && (blk_num + 1 >= eff_blocks());
    elem_q.push_back(x);
  endtask

  task automatic close_block();
    byte_pos = 0;
    blk_num = (blk_num + 1 >= eff_blocks()) ? 0 : blk_num + 1;
  endtask

  task automatic dequant_byte(logic [7:0] b);
    int j;
    if (byte_pos == 0) begin
      scale[7:0] = b;
      byte_pos = 1;
    end else if (byte_pos == 1) begin
      scale[15:8] = b;
      byte_pos = 2;
    end else if (!fmt_q8) begin
      j = (byte_pos - 2) & 15;
      high_nib[j] = b[7:4];
      push_elem(int'(b[3:0]) - 8, j);
      if (j == 15) begin
        for (int i = 0; i < 16; i++) push_elem(int'(high_nib[i]) - 8, 16 + i);
        close_block();
      end else byte_pos++;
    end else begin
      j = (byte_pos - 2) & 31;
      push_elem(int'($signed(b)), j);
      if (j == 31) close_block();
      else byte_pos++;
    end
  endtask

  // inputs change on the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_fire) begin
        if (byte_q.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_tvalid <= 1'b1;
          in_tdata <= byte_q.pop_front();
        end else in_tvalid <= 1'b0;
      end
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      if (elem_q.size() == 0) begin
        $display("%0t: unexpected element bits=%h idx=%0d", $time,
                 out_tdata[31:0], out_tdata[44:32]);
        errors++;
      end else begin
        elem_t x;
        x = elem_q.pop_front();
        if (x != {out_tdata[31:0], out_tdata[44:32], out_tuser, out_tlast}) begin
          $display("%0t: expected bits=%h idx=%0d blk=%b row=%b, got bits=%h idx=%0d blk=%b row=%b",
                   $time, x.bits, x.idx, x.last_blk, x.last_row, out_tdata[31:0],
                   out_tdata[44:32], out_tuser, out_tlast);
          errors++;
        end
      end
    end
    if (rst_n && in_tvalid && in_tready) dequant_byte(in_tdata);
    if (rst_n && (in_tvalid && in_tready || out_tvalid && out_tready ||
                  byte_q.size() == 0 && elem_q.size() == 0 && !in_tvalid))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == qbd_pkg::CfgQuantFormat) fmt_q8 = val[0];
    else if (idx == qbd_pkg::CfgBlocksPerRow) row_blocks = val;
    if (idx == qbd_pkg::CfgQuantFormat || idx == qbd_pkg::CfgBlocksPerRow) begin
      byte_pos = 0;
      blk_num = 0;
    end
  endtask

  task automatic drain();
    wait (byte_q.size() == 0 && elem_q.size() == 0 && !in_tvalid);
    repeat (30) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(9))
      0:       return {1'($urandom_range(1)), 5'h00, 10'($urandom)};
      1:       return {1'($urandom_range(1)), 15'h0000};
      2:       return {1'($urandom_range(1)), 5'h1F, 10'd0};
      3:       return {1'($urandom_range(1)), 5'h1F, 10'($urandom_range(1023, 1))};
      4:       return 16'($urandom);
      default: return {1'($urandom_range(1)), 5'($urandom_range(30, 1)), 10'($urandom)};
    endcase
  endfunction

  // one block of random content, sometimes cut short
  task automatic push_block(logic q8);
    logic [15:0] s;
    int n;
    s = rand_scale();
    n = q8 ? 32 : 16;
    if ($urandom_range(9) == 0) n = $urandom_range(n - 1);
    byte_q.push_back(s[7:0]);
    byte_q.push_back(s[15:8]);
    repeat (n) byte_q.push_back(8'($urandom));
  endtask

  initial begin
    int ph;
    int sent;
    logic q8;
    fmt_q8 = qbd_pkg::FmtQ4;
    row_blocks = 9'd1;
    byte_pos = 0;
    scale = '0;
    blk_num = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 37;
    recv_idle = 79;

    // negative zero scale with extreme nibbles, then infinite scale in eight-bit mode
    byte_q = '{8'h00, 8'h80, 8'h00, 8'hFF, 8'h88, 8'h0F, 8'hF0, 8'h12, 8'h34, 8'h56,
               8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF1, 8'h7E, 8'h81, 8'h5A, 8'hA5};
    drain();
    write_reg(qbd_pkg::CfgQuantFormat, 9'h001);
    write_reg(qbd_pkg::CfgBlocksPerRow, 9'd0);
    write_reg(2'd2, 9'h1FF);
    write_reg(2'd3, 9'h155);
    byte_q = '{8'h00, 8'h7C, 8'h00, 8'h80, 8'h7F, 8'hFF, 8'h01};
    drain();
    write_reg(qbd_pkg::CfgBlocksPerRow, 9'd1);
    byte_q = '{8'h01, 8'h7E};
    repeat (32) byte_q.push_back(8'($urandom));
    drain();

    for (ph = 0; ph < 9; ph++) begin
      send_idle = (ph < 3) ? 37 : (ph < 6) ? 79 : 0;
      recv_idle = (ph < 3) ? 79 : (ph < 6) ? 37 : 0;
      q8 = ph[0];
      write_reg(qbd_pkg::CfgQuantFormat, {8'($urandom), q8});
      case (ph % 6)
        0: write_reg(qbd_pkg::CfgBlocksPerRow, 9'd1);
        1: write_reg(qbd_pkg::CfgBlocksPerRow, 9'd2);
        2: write_reg(qbd_pkg::CfgBlocksPerRow, 9'd511);
        3: write_reg(qbd_pkg::CfgBlocksPerRow, 9'd256);
        4: write_reg(qbd_pkg::CfgBlocksPerRow, 9'd0);
        default: write_reg(qbd_pkg::CfgBlocksPerRow, 9'($urandom_range(5, 3)));
      endcase
      sent = 0;
      while (sent < 30) begin
        push_block(q8);
        sent = byte_q.size();
      end
      if ($urandom_range(1)) byte_q.push_back(8'($urandom));
      drain();
    end

    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule

// File: quantized_block_dequantizer_unit.f
rtl/qbd_pkg.sv
rtl/qbd_ctrl.sv
rtl/qbd_fmul.sv
rtl/quantized_block_dequantizer_unit.sv
sim/tb.sv
